/* design/ppc_pkg.sv */
// Shared widths, constants, types and the arctangent table for the pursuit controller.
`default_nettype none

package ppc_pkg;

    localparam int XW = 27;
    localparam int ZW = 28;
    localparam int GW = 13;
    localparam int LW = 15;
    localparam int FW = 16;
    localparam int DW = 18;
    localparam int BW = 16;
    localparam int PW = XW + 18;

    localparam logic signed [ZW-1:0] HALF_PI_Q24   = 28'sd26353589;
    localparam logic        [16:0]   GAIN_CORR_Q16 = 17'd39797;
    localparam logic signed [BW-1:0] PI_Q13        = 16'sd25736;

    typedef enum logic [1:0] {
        REG_LINEAR_GAIN,
        REG_ANGULAR_GAIN,
        REG_LINEAR_LIMIT,
        REG_ANGULAR_LIMIT
    } t_reg_index;

    typedef struct packed {
        logic                 valid;
        logic                 zero;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cordic_word;

    typedef struct packed {
        logic signed [GW-1:0] linear_gain;
        logic signed [GW-1:0] angular_gain;
        logic        [LW-1:0] linear_limit;
        logic        [LW-1:0] angular_limit;
    } t_cfg;

    function automatic logic signed [ZW-1:0] atan_step(input int unsigned i);
        logic signed [ZW-1:0] v;
        v = '0;
        if (i < 8) begin
            case (i)
                0: v = 28'sd13176795;
                1: v = 28'sd7778716;
                2: v = 28'sd4110060;
                3: v = 28'sd2086331;
                4: v = 28'sd1047214;
                5: v = 28'sd524117;
                6: v = 28'sd262123;
                7: v = 28'sd131069;
                default: v = '0;
            endcase
        end else if (i <= 24) begin
            v = ZW'(1) <<< (24 - i);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* design/ppc_cordic_cell.sv */
// One vectoring CORDIC micro-rotation with its output register.
`default_nettype none

module ppc_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  ppc_pkg::t_cordic_word i_word,
    output ppc_pkg::t_cordic_word o_word
);
    import ppc_pkg::*;

    localparam logic signed [ZW-1:0] ANGLE = atan_step(STAGE);

    t_cordic_word         r_word;
    t_cordic_word         n_word;
    logic signed [XW-1:0] x_in;
    logic signed [XW-1:0] y_in;
    logic signed [ZW-1:0] z_in;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    always_comb begin
        x_in   = i_word.x;
        y_in   = i_word.y;
        z_in   = i_word.z;
        xs     = x_in >>> STAGE;
        ys     = y_in >>> STAGE;
        n_word = i_word;
        if (!y_in[XW-1]) begin
            n_word.x = x_in + ys;
            n_word.y = y_in - xs;
            n_word.z = z_in + ANGLE;
        end else begin
            n_word.x = x_in - ys;
            n_word.y = y_in + xs;
            n_word.z = z_in - ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

/* design/ppc_scale.sv */
// Gain correction, bearing rounding, gain multiply and saturation pipeline.
`default_nettype none

module ppc_scale (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  ppc_pkg::t_cordic_word i_word,
    input  ppc_pkg::t_cfg         i_cfg,
    output logic                  o_valid,
    output logic [15:0]           o_linear_cmd,
    output logic [15:0]           o_angular_cmd
);
    import ppc_pkg::*;

    localparam int ZRW = ZW - 11;
    localparam int LPW = GW + DW;
    localparam int APW = GW + BW;

    logic                  r_a_valid;
    logic                  r_a_zero;
    logic signed [PW-1:0]  r_a_prod;
    logic signed [ZW-1:0]  r_a_z;
    logic signed [XW-1:0]  x_in;
    logic signed [17:0]    corr;
    logic signed [PW-1:0]  n_a_prod;

    logic                  r_b_valid;
    logic signed [DW-1:0]  r_b_dist;
    logic signed [BW-1:0]  r_b_bear;
    logic signed [DW-1:0]  n_b_dist;
    logic signed [BW-1:0]  n_b_bear;
    logic signed [PW-1:0]  dist_sum;
    logic signed [ZW-1:0]  z_sum;
    logic signed [ZRW-1:0] z_round;

    logic                  r_c_valid;
    logic signed [LPW-1:0] r_c_lin;
    logic signed [APW-1:0] r_c_ang;

    logic                  r_d_valid;
    logic signed [FW-1:0]  r_d_lin;
    logic signed [FW-1:0]  r_d_ang;
    logic signed [LPW-1:0] lin_sum;
    logic signed [LPW-1:0] lin_lim;
    logic signed [APW-1:0] ang_sum;
    logic signed [APW-1:0] ang_lim;
    logic signed [FW-1:0]  n_d_lin;
    logic signed [FW-1:0]  n_d_ang;

    always_comb begin
        x_in     = i_word.x;
        corr     = signed'({1'b0, GAIN_CORR_Q16});
        n_a_prod = x_in * corr;
    end

    always_comb begin
        dist_sum = r_a_prod + PW'(64'sd8388608);
        z_sum    = r_a_z + ZW'(32'sd1024);
        z_round  = ZRW'(z_sum >>> 11);
        if (r_a_zero) begin
            n_b_dist = '0;
            n_b_bear = '0;
        end else begin
            n_b_dist = DW'(dist_sum >>> 24);
            if (z_round > ZRW'(PI_Q13)) begin
                n_b_bear = PI_Q13;
            end else if (z_round < -ZRW'(PI_Q13)) begin
                n_b_bear = -PI_Q13;
            end else begin
                n_b_bear = BW'(z_round);
            end
        end
    end

    always_comb begin
        lin_sum = (r_c_lin + LPW'(32'sd128)) >>> 8;
        lin_lim = LPW'(signed'({1'b0, i_cfg.linear_limit}));
        if (lin_sum > lin_lim) begin
            n_d_lin = FW'(lin_lim);
        end else if (lin_sum < -lin_lim) begin
            n_d_lin = FW'(-lin_lim);
        end else begin
            n_d_lin = FW'(lin_sum);
        end
        ang_sum = (r_c_ang + APW'(32'sd4096)) >>> 13;
        ang_lim = APW'(signed'({1'b0, i_cfg.angular_limit}));
        if (ang_sum > ang_lim) begin
            n_d_ang = FW'(ang_lim);
        end else if (ang_sum < -ang_lim) begin
            n_d_ang = FW'(-ang_lim);
        end else begin
            n_d_ang = FW'(ang_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_word.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_zero <= i_word.zero;
            r_a_prod <= n_a_prod;
            r_a_z    <= i_word.z;
            r_b_dist <= n_b_dist;
            r_b_bear <= n_b_bear;
            r_c_lin  <= i_cfg.linear_gain * r_b_dist;
            r_c_ang  <= i_cfg.angular_gain * r_b_bear;
            r_d_lin  <= n_d_lin;
            r_d_ang  <= n_d_ang;
        end
    end

    assign o_valid       = r_d_valid;
    assign o_linear_cmd  = r_d_lin;
    assign o_angular_cmd = r_d_ang;

endmodule

`default_nettype wire

/* design/pursuit_polar_p_controller.sv */
// Top level of the proportional pursuit controller with a pipelined CORDIC front end.
`default_nettype none

// Takes one offset word per cycle while o_in_stall is low and returns its linear and angular
// commands through one pre-rotation register, one CORDIC cell per stage,
// then four registers for gain correction, rounding, gain multiply and saturation.
// The whole chain advances together and holds only while a finished word waits
// under output stall. A word with lookup_ok low is taken but gives no result.

module pursuit_polar_p_controller #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_offset_x,
    input  logic [15:0] i_offset_y,
    input  logic        i_lookup_ok,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_linear_cmd,
    output logic [15:0] o_angular_cmd
);
    import ppc_pkg::*;

    t_cfg                 r_cfg;
    t_cordic_word         r_pre;
    t_cordic_word         n_pre;
    t_cordic_word         chain [0:CORDIC_STAGES];
    logic                 en;
    logic signed [XW-1:0] x0;
    logic signed [XW-1:0] y0;

    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.linear_gain   <= 13'sd307;
            r_cfg.angular_gain  <= 13'sd1024;
            r_cfg.linear_limit  <= 15'd512;
            r_cfg.angular_limit <= 15'd1536;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_LINEAR_GAIN:   r_cfg.linear_gain   <= i_cfg_data[GW-1:0];
                REG_ANGULAR_GAIN:  r_cfg.angular_gain  <= i_cfg_data[GW-1:0];
                REG_LINEAR_LIMIT:  r_cfg.linear_limit  <= i_cfg_data;
                REG_ANGULAR_LIMIT: r_cfg.angular_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        x0          = XW'(signed'({i_offset_x, 8'd0}));
        y0          = XW'(signed'({i_offset_y, 8'd0}));
        n_pre.valid = i_in_valid && i_lookup_ok;
        n_pre.zero  = (i_offset_x == 16'd0) && (i_offset_y == 16'd0);
        n_pre.x     = x0;
        n_pre.y     = y0;
        n_pre.z     = '0;
        if (x0[XW-1]) begin
            if (!y0[XW-1]) begin
                n_pre.x = y0;
                n_pre.y = -x0;
                n_pre.z = HALF_PI_Q24;
            end else begin
                n_pre.x = -y0;
                n_pre.y = x0;
                n_pre.z = -HALF_PI_Q24;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre.valid <= 1'b0;
        end else if (en) begin
            r_pre <= n_pre;
        end
    end

    assign chain[0] = r_pre;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        ppc_cordic_cell #(
            .STAGE(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_word (chain[g]),
            .o_word (chain[g+1])
        );
    end

    ppc_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_word       (chain[CORDIC_STAGES]),
        .i_cfg        (r_cfg),
        .o_valid      (o_out_valid),
        .o_linear_cmd (o_linear_cmd),
        .o_angular_cmd(o_angular_cmd)
    );

endmodule

`default_nettype wire

/* design/ppc_checker.sv */
// Port-level checks for the pursuit controller and their bind to the top level.
`default_nettype none

module ppc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_linear_cmd,
    input logic [15:0] o_angular_cmd
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_linear_cmd)
            && $stable(o_angular_cmd))
        else $error("stalled output word changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked output word");

    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_linear_cmd != 16'h8000 && o_angular_cmd != 16'h8000)
        else $error("command outside its symmetric range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

endmodule

bind pursuit_polar_p_controller ppc_checker u_ppc_checker (.*);

`default_nettype wire
